### rtl/fgmn_pkg.sv
// Package for the functional graph meeting node block.
// Shared types, field widths and register codes; no dependencies.
package fgmn_pkg;

  localparam int IDX_W         = 10;  // node index field width
  localparam int DIST_W        = 10;  // walk distance, below 1024 by construction
  localparam int SUM_W         = DIST_W + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_NODES_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_START_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_B = 2'd1;

  typedef struct packed {
    logic [IDX_W-1:0] successor;
    logic             has_successor;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] meeting_node;
    logic             found;
  } out_item_t;

  // successor memory word
  typedef struct packed {
    logic             has;
    logic [IDX_W-1:0] succ;
  } succ_entry_t;

  // distance memory word: both walks share one entry
  typedef struct packed {
    logic              reached_a;
    logic [DIST_W-1:0] dist_a;
    logic              reached_b;
    logic [DIST_W-1:0] dist_b;
  } dist_entry_t;

endpackage

### rtl/functional_graph_meeting_node.sv
// Top level of the functional graph meeting node block.
// Holds the start registers and ties fgmn_ctrl to two fgmn_ram memories.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one successor entry per
//   beat, node 0 first; a beat with last set closes the graph. Loading takes
//   one beat per cycle. Entries past MAX_NODES are dropped.
//   After the last beat the block stalls input while it walks from start_a
//   and start_b (per node visited, one memory read and then one
//   read-modify-write) and then scans all loaded nodes, clearing the
//   distance memory as it goes.
//   One result beat (meeting_node, found) follows on out_valid/out_stall.
//   Loading of the next graph starts once the result is in the output
//   register; a stalled result holds and blocks only the next result.
//   Configuration: cfg_valid/cfg_ready, index 0 = start_a, 1 = start_b,
//   others ignored; write only while idle. cfg_ready is always high.
//   Reset (rst, synchronous): start registers go to 0, then a clearing pass
//   over all MAX_NODES entries sweeps the distance memory with input stalled.
module functional_graph_meeting_node import fgmn_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int AW       = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IDX_W-1:0]     cfg_data
);

  logic [IDX_W-1:0] start_a;
  logic [IDX_W-1:0] start_b;

  logic          smem_we;
  logic [AW-1:0] smem_waddr;
  succ_entry_t   smem_wdata;
  logic [AW-1:0] smem_raddr;
  succ_entry_t   smem_rdata;
  logic          dmem_we;
  logic [AW-1:0] dmem_waddr;
  dist_entry_t   dmem_wdata;
  logic [AW-1:0] dmem_raddr;
  dist_entry_t   dmem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_a <= '0;
      start_b <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_A: start_a <= cfg_data;
        REG_START_B: start_b <= cfg_data;
        default: ;
      endcase
    end
  end

  fgmn_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .start_a    (start_a),
    .start_b    (start_b),
    .smem_we    (smem_we),
    .smem_waddr (smem_waddr),
    .smem_wdata (smem_wdata),
    .smem_raddr (smem_raddr),
    .smem_rdata (smem_rdata),
    .dmem_we    (dmem_we),
    .dmem_waddr (dmem_waddr),
    .dmem_wdata (dmem_wdata),
    .dmem_raddr (dmem_raddr),
    .dmem_rdata (dmem_rdata)
  );

  fgmn_ram #(.WIDTH($bits(succ_entry_t)), .DEPTH(MAX_NODES)) u_succ_mem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (smem_waddr),
    .wdata (smem_wdata),
    .raddr (smem_raddr),
    .rdata (smem_rdata)
  );

  fgmn_ram #(.WIDTH($bits(dist_entry_t)), .DEPTH(MAX_NODES)) u_dist_mem (
    .clk   (clk),
    .we    (dmem_we),
    .waddr (dmem_waddr),
    .wdata (dmem_wdata),
    .raddr (dmem_raddr),
    .rdata (dmem_rdata)
  );

endmodule

### rtl/fgmn_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. Uses no package items.
module fgmn_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/fgmn_ctrl.sv
// Sequencer for the meeting node block: clear, load, two walks, scan, result.
// Drives both memories (fgmn_ram) through their ports; uses fgmn_pkg.
module fgmn_ctrl import fgmn_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int AW       = $clog2(MAX_NODES),
  localparam int CW       = $clog2(MAX_NODES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic [IDX_W-1:0]      start_a,
  input  logic [IDX_W-1:0]      start_b,
  output logic                  smem_we,
  output logic [AW-1:0]         smem_waddr,
  output succ_entry_t           smem_wdata,
  output logic [AW-1:0]         smem_raddr,
  input  succ_entry_t           smem_rdata,
  output logic                  dmem_we,
  output logic [AW-1:0]         dmem_waddr,
  output dist_entry_t           dmem_wdata,
  output logic [AW-1:0]         dmem_raddr,
  input  dist_entry_t           dmem_rdata
);

  localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_LOAD, S_WALK_START, S_WALK_RD, S_WALK_CHK, S_SCAN, S_EMIT
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     v;
  logic [DIST_W-1:0] d;
  logic              walk_b;
  logic [CW-1:0]     scan_idx;
  logic              pipe_v;
  logic [AW-1:0]     pipe_addr;
  logic [SUM_W-1:0]  best_sum;
  logic [IDX_W-1:0]  best_node;
  logic              found;

  logic              in_acc;
  logic [IDX_W-1:0]  start_sel;
  logic              start_ok;
  logic              own_seen;
  logic              succ_ok;
  logic [XW-1:0]     succ_x;
  logic [XW-1:0]     start_x;
  logic [XW-1:0]     pipe_x;
  logic [SUM_W-1:0]  sum;
  logic              both;
  dist_entry_t       upd;

  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign start_sel = walk_b ? start_b : start_a;
  assign start_ok  = CMPW'(start_sel) < CMPW'(cnt);
  assign start_x   = XW'(start_sel);
  assign own_seen  = walk_b ? dmem_rdata.reached_b : dmem_rdata.reached_a;
  assign succ_ok   = smem_rdata.has && (CMPW'(smem_rdata.succ) < CMPW'(cnt));
  assign succ_x    = XW'(smem_rdata.succ);
  assign pipe_x    = XW'(pipe_addr);
  assign both      = dmem_rdata.reached_a && dmem_rdata.reached_b;
  assign sum       = SUM_W'(dmem_rdata.dist_a) + SUM_W'(dmem_rdata.dist_b);

  always_comb begin
    upd = dmem_rdata;
    if (walk_b) begin
      upd.reached_b = 1'b1;
      upd.dist_b    = d;
    end else begin
      upd.reached_a = 1'b1;
      upd.dist_a    = d;
    end
  end

  // memory port steering
  always_comb begin
    smem_we    = in_acc && (cnt < CW'(MAX_NODES));
    smem_waddr = cnt[AW-1:0];
    smem_wdata = '{has: in_data.has_successor, succ: in_data.successor};
    smem_raddr = v;
    dmem_we    = 1'b0;
    dmem_waddr = v;
    dmem_wdata = upd;
    dmem_raddr = v;
    case (state)
      S_CLEAR: begin
        dmem_we    = 1'b1;
        dmem_waddr = clr_addr;
        dmem_wdata = '0;
      end
      S_WALK_CHK: begin
        dmem_we = !own_seen;
      end
      S_SCAN: begin
        // clear the entry read last cycle while reading the next one
        dmem_raddr = scan_idx[AW-1:0];
        dmem_we    = pipe_v;
        dmem_waddr = pipe_addr;
        dmem_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      walk_b    <= 1'b0;
      pipe_v    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // emit reloads the output register itself when it fires
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_NODES - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (in_acc) begin
            if (cnt < CW'(MAX_NODES)) begin
              cnt <= cnt + 1'b1;
            end
            if (in_data.last) begin
              walk_b <= 1'b0;
              state  <= S_WALK_START;
            end
          end
        end
        S_WALK_START: begin
          if (start_ok) begin
            v     <= start_x[AW-1:0];
            d     <= '0;
            state <= S_WALK_RD;
          end else if (!walk_b) begin
            walk_b <= 1'b1;
          end else begin
            scan_idx <= '0;
            pipe_v   <= 1'b0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (!own_seen && succ_ok) begin
            v     <= succ_x[AW-1:0];
            d     <= d + 1'b1;
            state <= S_WALK_RD;
          end else if (!walk_b) begin
            walk_b <= 1'b1;
            state  <= S_WALK_START;
          end else begin
            scan_idx <= '0;
            pipe_v   <= 1'b0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx < cnt) begin
            pipe_v    <= 1'b1;
            pipe_addr <= scan_idx[AW-1:0];
            scan_idx  <= scan_idx + 1'b1;
          end else begin
            pipe_v <= 1'b0;
            if (!pipe_v) begin
              state <= S_EMIT;
            end
          end
          if (pipe_v && both && (!found || sum < best_sum)) begin
            found     <= 1'b1;
            best_sum  <= sum;
            best_node <= pipe_x[IDX_W-1:0];
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.found        <= found;
            out_data.meeting_node <= found ? best_node : '0;
            cnt                   <= '0;
            state                 <= S_LOAD;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_NODES))
    else $error("node count above capacity");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_CHK && dmem_we) |-> (CMPW'(dmem_waddr) < CMPW'(cnt)))
    else $error("walk wrote a node outside the loaded set");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= cnt)
    else $error("scan ran past node count");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result beat raised outside emit");

endmodule
